### src/bmhq_pkg.sv
// Shared constants, codes and cell control type of the binary min-heap queue.
`default_nettype none
package bmhq_pkg;

   localparam int DEPTH_DEF    = 64;
   localparam int KEY_BITS_DEF = 32;
   localparam int TAG_BITS_DEF = 16;

   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Per-level strobes from the controller to one cell.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_odd;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### src/bmhq_cell.sv
// One heap level: sibling pairs stored as even and odd halves, read a pair at a time.
`default_nettype none
module bmhq_cell #(
   parameter int LEVEL    = 0,
   parameter int KEY_BITS = bmhq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS = bmhq_pkg::TAG_BITS_DEF,
   parameter int ROW_BITS = 1
) (
   input  wire                          clock,
   input  bmhq_pkg::cell_ctrl_type      ctrl,
   input  wire logic [ROW_BITS-1:0]     rd_row,
   input  wire logic [ROW_BITS-1:0]     wr_row,
   input  wire logic [KEY_BITS-1:0]     wr_key,
   input  wire logic [TAG_BITS-1:0]     wr_tag,
   output logic      [KEY_BITS-1:0]     rd_key_even,
   output logic      [KEY_BITS-1:0]     rd_key_odd,
   output logic      [TAG_BITS-1:0]     rd_tag_even,
   output logic      [TAG_BITS-1:0]     rd_tag_odd
);

   localparam int CRW  = (LEVEL > 1) ? LEVEL - 1 : 1;
   localparam int ROWS = 2 ** CRW;

   logic [KEY_BITS-1:0] key_even_ff [ROWS];
   logic [KEY_BITS-1:0] key_odd_ff  [ROWS];
   logic [TAG_BITS-1:0] tag_even_ff [ROWS];
   logic [TAG_BITS-1:0] tag_odd_ff  [ROWS];

   logic [KEY_BITS-1:0] rd_key_even_ff, rd_key_odd_ff;
   logic [TAG_BITS-1:0] rd_tag_even_ff, rd_tag_odd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         if (ctrl.wr_odd) begin
            key_odd_ff[wr_row[CRW-1:0]] <= wr_key;
            tag_odd_ff[wr_row[CRW-1:0]] <= wr_tag;
         end else begin
            key_even_ff[wr_row[CRW-1:0]] <= wr_key;
            tag_even_ff[wr_row[CRW-1:0]] <= wr_tag;
         end
      end
      if (ctrl.rd_en) begin
         rd_key_even_ff <= key_even_ff[rd_row[CRW-1:0]];
         rd_key_odd_ff  <= key_odd_ff[rd_row[CRW-1:0]];
         rd_tag_even_ff <= tag_even_ff[rd_row[CRW-1:0]];
         rd_tag_odd_ff  <= tag_odd_ff[rd_row[CRW-1:0]];
      end
   end

   assign rd_key_even = rd_key_even_ff;
   assign rd_key_odd  = rd_key_odd_ff;
   assign rd_tag_even = rd_tag_even_ff;
   assign rd_tag_odd  = rd_tag_odd_ff;

endmodule
`default_nettype wire

### src/binary_min_heap_queue_top.sv
// Binary min-heap queue: per-level cells and the sift controller.
// A push climbs level by level from the new slot; a pop moves the last entry to the root and
// sinks it level by level; a remove scans the slots in order, then sifts the moved entry.
// One word is in work at a time.
// Synchronous reset empties the heap at once; entry storage is not cleared.
`default_nettype none
module binary_min_heap_queue_top #(
   parameter int DEPTH    = bmhq_pkg::DEPTH_DEF,
   parameter int KEY_BITS = bmhq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS = bmhq_pkg::TAG_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_func,
   input  wire logic [KEY_BITS-1:0]              req_key,
   input  wire logic [TAG_BITS-1:0]              req_tag,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic      [1:0]                       rsp_status,
   output logic      [KEY_BITS-1:0]              rsp_out_key,
   output logic      [TAG_BITS-1:0]              rsp_out_tag,
   output logic      [$clog2(DEPTH+1)-1:0]       rsp_size,
   output logic                                  rsp_top_valid,
   output logic      [KEY_BITS-1:0]              rsp_top_key,
   output logic      [TAG_BITS-1:0]              rsp_top_tag
);

   localparam int CW  = $clog2(DEPTH + 1);
   localparam int NW  = CW + 1;
   localparam int LV  = CW;
   localparam int LVW = (LV > 1) ? $clog2(LV) : 1;
   localparam int RW  = (LV > 2) ? LV - 2 : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_UP, S_UP_CMP, S_DOWN, S_DOWN_CMP, S_POP_ROOT, S_POP_LAST,
      S_SCAN, S_RM_LAST, S_TOP, S_RESP
   } state_type;

   function automatic logic [LVW-1:0] level_of(input logic [NW-1:0] n);
      logic [LVW-1:0] l;
      l = '0;
      for (int i = 0; i < LV; i++) begin
         if (n[i]) l = LVW'(i);
      end
      return l;
   endfunction

   // Row of a node inside its level: the parent's offset within the level above.
   function automatic logic [RW-1:0] row_of(input logic [NW-1:0] n, input logic [LVW-1:0] l);
      logic [NW-1:0] r;
      r = n >> 1;
      if (l != '0) r[l - LVW'(1)] = 1'b0;
      return r[RW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NW-1:0]       node_ff, node_in;
   logic [1:0]          status_ff, status_in;
   logic [KEY_BITS-1:0] mov_key_ff, mov_key_in, gone_key_ff, gone_key_in;
   logic [TAG_BITS-1:0] mov_tag_ff, mov_tag_in, tag_ff, tag_in;
   logic [KEY_BITS-1:0] okey_ff, okey_in;
   logic [TAG_BITS-1:0] otag_ff, otag_in;
   logic [LVW-1:0]      rd_lvl_ff, rd_lvl_in;
   logic                rd_odd_ff, rd_odd_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0] rsp_out_key_ff, rsp_out_key_in, rsp_top_key_ff, rsp_top_key_in;
   logic [TAG_BITS-1:0] rsp_out_tag_ff, rsp_out_tag_in, rsp_top_tag_ff, rsp_top_tag_in;
   logic [CW-1:0]       rsp_size_ff, rsp_size_in;
   logic                rsp_top_valid_ff, rsp_top_valid_in;

   logic                mem_rd, mem_wr;
   logic [NW-1:0]       mem_rd_node, mem_wr_node;
   logic [KEY_BITS-1:0] mem_wr_key;
   logic [TAG_BITS-1:0] mem_wr_tag;
   logic [LVW-1:0]      rd_lvl, wr_lvl;
   logic [RW-1:0]       rd_row, wr_row;

   logic [KEY_BITS-1:0] cell_key_even [LV];
   logic [KEY_BITS-1:0] cell_key_odd  [LV];
   logic [TAG_BITS-1:0] cell_tag_even [LV];
   logic [TAG_BITS-1:0] cell_tag_odd  [LV];

   logic [KEY_BITS-1:0] sel_key, lo_key, hi_key;
   logic [TAG_BITS-1:0] sel_tag, lo_tag, hi_tag;
   logic [NW-1:0]       cnt_ext, child;
   logic                hi_ok, take_lo, take_hi;

   assign rd_lvl = level_of(mem_rd_node);
   assign wr_lvl = level_of(mem_wr_node);
   assign rd_row = row_of(mem_rd_node, rd_lvl);
   assign wr_row = row_of(mem_wr_node, wr_lvl);

   for (genvar g = 0; g < LV; g++) begin : g_level
      bmhq_pkg::cell_ctrl_type ctrl;
      assign ctrl = {mem_rd && (rd_lvl == LVW'(g)), mem_wr && (wr_lvl == LVW'(g)),
                     mem_wr_node[0]};
      bmhq_cell #(
         .LEVEL(g), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS), .ROW_BITS(RW)
      ) u_cell (
         .clock(clock), .ctrl(ctrl), .rd_row(rd_row), .wr_row(wr_row),
         .wr_key(mem_wr_key), .wr_tag(mem_wr_tag),
         .rd_key_even(cell_key_even[g]), .rd_key_odd(cell_key_odd[g]),
         .rd_tag_even(cell_tag_even[g]), .rd_tag_odd(cell_tag_odd[g])
      );
   end

   assign lo_key  = cell_key_even[rd_lvl_ff];
   assign hi_key  = cell_key_odd[rd_lvl_ff];
   assign lo_tag  = cell_tag_even[rd_lvl_ff];
   assign hi_tag  = cell_tag_odd[rd_lvl_ff];
   assign sel_key = rd_odd_ff ? hi_key : lo_key;
   assign sel_tag = rd_odd_ff ? hi_tag : lo_tag;

   assign cnt_ext = {1'b0, cnt_ff};
   assign child   = node_ff << 1;
   assign hi_ok   = (child + NW'(1)) <= cnt_ext;
   // The left child wins a tie between children; the moving entry wins a tie with either.
   assign take_lo = (lo_key < mov_key_ff) && !(hi_ok && (hi_key < lo_key));
   assign take_hi = hi_ok && (hi_key < mov_key_ff) && (hi_key < lo_key);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      node_in     = node_ff;
      status_in   = status_ff;
      mov_key_in  = mov_key_ff;
      mov_tag_in  = mov_tag_ff;
      gone_key_in = gone_key_ff;
      tag_in      = tag_ff;
      okey_in     = okey_ff;
      otag_in     = otag_ff;
      mem_rd      = 1'b0;
      mem_rd_node = node_ff;
      mem_wr      = 1'b0;
      mem_wr_node = node_ff;
      mem_wr_key  = mov_key_ff;
      mem_wr_tag  = mov_tag_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_out_key_in   = rsp_out_key_ff;
      rsp_out_tag_in   = rsp_out_tag_ff;
      rsp_size_in      = rsp_size_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_top_key_in   = rsp_top_key_ff;
      rsp_top_tag_in   = rsp_top_tag_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = bmhq_pkg::STATUS_OK;
               okey_in   = '0;
               otag_in   = '0;
               tag_in    = req_tag;
               state_in  = S_TOP;
               unique case (req_func)
                  bmhq_pkg::FUNC_PUSH: begin
                     if (cnt_ext == NW'(DEPTH)) begin
                        status_in = bmhq_pkg::STATUS_FULL;
                     end else begin
                        node_in    = cnt_ext + NW'(1);
                        cnt_in     = cnt_ff + CW'(1);
                        mov_key_in = req_key;
                        mov_tag_in = req_tag;
                        state_in   = S_UP;
                     end
                  end
                  bmhq_pkg::FUNC_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = bmhq_pkg::STATUS_EMPTY;
                     end else begin
                        mem_rd      = 1'b1;
                        mem_rd_node = NW'(1);
                        state_in    = S_POP_ROOT;
                     end
                  end
                  bmhq_pkg::FUNC_REMOVE: begin
                     if (cnt_ff == '0) begin
                        status_in = bmhq_pkg::STATUS_NOT_FOUND;
                     end else begin
                        node_in     = NW'(1);
                        mem_rd      = 1'b1;
                        mem_rd_node = NW'(1);
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            if (node_ff == NW'(1)) begin
               mem_wr   = 1'b1;
               state_in = S_TOP;
            end else begin
               mem_rd      = 1'b1;
               mem_rd_node = node_ff >> 1;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_wr = 1'b1;
            if (mov_key_ff < sel_key) begin
               mem_wr_key = sel_key;
               mem_wr_tag = sel_tag;
               node_in    = node_ff >> 1;
               state_in   = S_UP;
            end else begin
               state_in = S_TOP;
            end
         end
         S_DOWN: begin
            if (child > cnt_ext) begin
               mem_wr   = 1'b1;
               state_in = S_TOP;
            end else begin
               mem_rd      = 1'b1;
               mem_rd_node = child;
               state_in    = S_DOWN_CMP;
            end
         end
         S_DOWN_CMP: begin
            mem_wr = 1'b1;
            if (take_hi) begin
               mem_wr_key = hi_key;
               mem_wr_tag = hi_tag;
               node_in    = child + NW'(1);
               state_in   = S_DOWN;
            end else if (take_lo) begin
               mem_wr_key = lo_key;
               mem_wr_tag = lo_tag;
               node_in    = child;
               state_in   = S_DOWN;
            end else begin
               state_in = S_TOP;
            end
         end
         S_POP_ROOT: begin
            okey_in     = sel_key;
            otag_in     = sel_tag;
            mem_rd      = 1'b1;
            mem_rd_node = cnt_ext;
            cnt_in      = cnt_ff - CW'(1);
            state_in    = S_POP_LAST;
         end
         S_POP_LAST: begin
            mov_key_in = sel_key;
            mov_tag_in = sel_tag;
            node_in    = NW'(1);
            state_in   = (cnt_ff == '0) ? S_TOP : S_DOWN;
         end
         S_SCAN: begin
            if (sel_tag == tag_ff) begin
               gone_key_in = sel_key;
               cnt_in      = cnt_ff - CW'(1);
               if (node_ff == cnt_ext) begin
                  state_in = S_TOP;
               end else begin
                  mem_rd      = 1'b1;
                  mem_rd_node = cnt_ext;
                  state_in    = S_RM_LAST;
               end
            end else if (node_ff == cnt_ext) begin
               status_in = bmhq_pkg::STATUS_NOT_FOUND;
               state_in  = S_TOP;
            end else begin
               node_in     = node_ff + NW'(1);
               mem_rd      = 1'b1;
               mem_rd_node = node_ff + NW'(1);
            end
         end
         S_RM_LAST: begin
            mov_key_in = sel_key;
            mov_tag_in = sel_tag;
            state_in   = (sel_key < gone_key_ff) ? S_UP : S_DOWN;
         end
         S_TOP: begin
            if (cnt_ff != '0) begin
               mem_rd      = 1'b1;
               mem_rd_node = NW'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_out_key_in   = okey_ff;
               rsp_out_tag_in   = otag_ff;
               rsp_size_in      = cnt_ff;
               rsp_top_valid_in = cnt_ff != '0;
               rsp_top_key_in   = (cnt_ff != '0) ? sel_key : '0;
               rsp_top_tag_in   = (cnt_ff != '0) ? sel_tag : '0;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rd_lvl_in = mem_rd ? rd_lvl : rd_lvl_ff;
      rd_odd_in = mem_rd ? mem_rd_node[0] : rd_odd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff          <= node_in;
      status_ff        <= status_in;
      mov_key_ff       <= mov_key_in;
      mov_tag_ff       <= mov_tag_in;
      gone_key_ff      <= gone_key_in;
      tag_ff           <= tag_in;
      okey_ff          <= okey_in;
      otag_ff          <= otag_in;
      rd_lvl_ff        <= rd_lvl_in;
      rd_odd_ff        <= rd_odd_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_out_key_ff   <= rsp_out_key_in;
      rsp_out_tag_ff   <= rsp_out_tag_in;
      rsp_size_ff      <= rsp_size_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_top_key_ff   <= rsp_top_key_in;
      rsp_top_tag_ff   <= rsp_top_tag_in;
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_key   = rsp_out_key_ff;
   assign rsp_out_tag   = rsp_out_tag_ff;
   assign rsp_size      = rsp_size_ff;
   assign rsp_top_valid = rsp_top_valid_ff;
   assign rsp_top_key   = rsp_top_key_ff;
   assign rsp_top_tag   = rsp_top_tag_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_full_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bmhq_pkg::STATUS_FULL) |-> rsp_size == CW'(DEPTH))
      else $error("full status with heap not full");

   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bmhq_pkg::STATUS_EMPTY) |-> rsp_size == '0)
      else $error("empty status with entries held");

   a_top_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_top_valid == (rsp_size != '0))
      else $error("top valid disagrees with size");

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the binary min-heap queue with a behavioral heap predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int DEPTH = 64;
   localparam int LIMIT = 4000000;
   localparam logic [1:0] FUNC_NOP = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_func = 0;
   logic [31:0] req_key = 0;
   logic [15:0] req_tag = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_status;
   logic [31:0] rsp_out_key;
   logic [15:0] rsp_out_tag;
   logic [6:0] rsp_size;
   logic rsp_top_valid;
   logic [31:0] rsp_top_key;
   logic [15:0] rsp_top_tag;

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] out_key;
      logic [15:0] out_tag;
      logic [6:0] size;
      logic top_valid;
      logic [31:0] top_key;
      logic [15:0] top_tag;
   } heap_reply_type;

   typedef struct {
      logic [1:0] func;
      logic [31:0] key;
      logic [15:0] tag;
      logic given;
      heap_reply_type reply;
   } stim_row_type;

   binary_min_heap_queue_top DUT (.*);

   always #10 clock = ~clock;

   // Predictor state.
   logic [31:0] pk [DEPTH];
   logic [15:0] pt [DEPTH];
   int count = 0;
   heap_reply_type pending_replies [$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 0;

   function automatic void swap_slots(int a, int b);
      logic [31:0] k;
      logic [15:0] t;
      k = pk[a]; t = pt[a];
      pk[a] = pk[b]; pt[a] = pt[b];
      pk[b] = k; pt[b] = t;
   endfunction

   function automatic void sift_up(int pos);
      while (pos > 0 && pk[pos] < pk[(pos - 1) / 2]) begin
         swap_slots(pos, (pos - 1) / 2);
         pos = (pos - 1) / 2;
      end
   endfunction

   function automatic void sift_down(int pos);
      int best;
      forever begin
         best = pos;
         if (2 * pos + 1 < count && pk[2 * pos + 1] < pk[best]) best = 2 * pos + 1;
         if (2 * pos + 2 < count && pk[2 * pos + 2] < pk[best]) best = 2 * pos + 2;
         if (best == pos) break;
         swap_slots(pos, best);
         pos = best;
      end
   endfunction

   function automatic heap_reply_type apply_heap_op(logic [1:0] func, logic [31:0] key,
                                                    logic [15:0] tag);
      heap_reply_type r;
      int i;
      logic [31:0] gone;
      r = '0;
      r.status = bmhq_pkg::STATUS_OK;
      case (func)
         bmhq_pkg::FUNC_PUSH: begin
            if (count >= DEPTH) r.status = bmhq_pkg::STATUS_FULL;
            else begin
               pk[count] = key; pt[count] = tag;
               count++;
               sift_up(count - 1);
            end
         end
         bmhq_pkg::FUNC_POP: begin
            if (count == 0) r.status = bmhq_pkg::STATUS_EMPTY;
            else begin
               r.out_key = pk[0]; r.out_tag = pt[0];
               count--;
               pk[0] = pk[count]; pt[0] = pt[count];
               sift_down(0);
            end
         end
         bmhq_pkg::FUNC_REMOVE: begin
            r.status = bmhq_pkg::STATUS_NOT_FOUND;
            for (i = 0; i < count; i++) if (pt[i] == tag) break;
            if (i < count) begin
               r.status = bmhq_pkg::STATUS_OK;
               gone = pk[i];
               count--;
               if (i != count) begin
                  pk[i] = pk[count]; pt[i] = pt[count];
                  if (pk[i] < gone) sift_up(i);
                  else sift_down(i);
               end
            end
         end
         default: ;
      endcase
      r.size = count[6:0];
      if (count > 0) begin
         r.top_valid = 1; r.top_key = pk[0]; r.top_tag = pt[0];
      end
      return r;
   endfunction

   // Valid stays high after an accepted word unless the sender idles before the next one.
   task automatic send_word(logic [1:0] func, logic [31:0] key, logic [15:0] tag,
                            logic given = 0, heap_reply_type fixed = '0);
      heap_reply_type r;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      r = apply_heap_op(func, key, tag);
      if (given && r !== fixed) begin
         errors++;
         if (errors <= 10)
            $display("table row mismatch: func %0d expected %h predicted %h", func, fixed, r);
      end
      pending_replies.push_back(r);
      req_valid <= 1; req_func <= func; req_key <= key; req_tag <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Result checker.
   always @(posedge clock) begin
      heap_reply_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_out_key, rsp_out_tag, rsp_size, rsp_top_valid,
                 rsp_top_key, rsp_top_tag};
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", got);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   // Receiver stall, with a long hold-off when asked.
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic random_burst(int n);
      int r;
      logic [15:0] t;
      for (int j = 0; j < n; j++) begin
         r = $urandom_range(99);
         t = (count > 0 && $urandom_range(3) != 0) ? pt[$urandom_range(count - 1)]
                                                   : 16'($urandom);
         if ($urandom_range(7) == 0) t = 16'($urandom_range(7));
         if (r < 50) send_word(bmhq_pkg::FUNC_PUSH,
                               $urandom_range(1) ? $urandom : $urandom_range(15), t);
         else if (r < 78) send_word(bmhq_pkg::FUNC_POP, $urandom, 16'($urandom));
         else if (r < 96) send_word(bmhq_pkg::FUNC_REMOVE, $urandom, t);
         else send_word(FUNC_NOP, $urandom, 16'($urandom));
      end
   endtask

   stim_row_type rows [$];
   initial begin
      for (int i = 0; i < DEPTH; i++) begin pk[i] = 0; pt[i] = 0; end
      // Directed table: given replies only where obvious.
      rows = '{
         '{bmhq_pkg::FUNC_POP, 32'h0, 16'h0, 1, '{bmhq_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0, 0}},
         '{bmhq_pkg::FUNC_REMOVE, 32'h0, 16'h5, 1,
           '{bmhq_pkg::STATUS_NOT_FOUND, 0, 0, 0, 0, 0, 0}},
         '{FUNC_NOP, 32'hFFFFFFFF, 16'hFFFF, 1, '{bmhq_pkg::STATUS_OK, 0, 0, 0, 0, 0, 0}},
         '{bmhq_pkg::FUNC_PUSH, 32'hFFFFFFFF, 16'hFFFF, 1,
           '{bmhq_pkg::STATUS_OK, 0, 0, 1, 1, 32'hFFFFFFFF, 16'hFFFF}},
         '{bmhq_pkg::FUNC_PUSH, 32'h0, 16'h0, 1, '{bmhq_pkg::STATUS_OK, 0, 0, 2, 1, 0, 0}},
         '{bmhq_pkg::FUNC_PUSH, 32'h0, 16'h7, 0, '0},
         '{bmhq_pkg::FUNC_PUSH, 32'h5, 16'h7, 0, '0},
         '{bmhq_pkg::FUNC_PUSH, 32'h5, 16'h9, 0, '0},
         '{bmhq_pkg::FUNC_REMOVE, 32'h0, 16'h7, 0, '0},
         '{bmhq_pkg::FUNC_REMOVE, 32'h0, 16'hFFFF, 0, '0},
         '{FUNC_NOP, 32'h0, 16'h0, 0, '0},
         '{bmhq_pkg::FUNC_POP, 32'h0, 16'h0, 0, '0},
         '{bmhq_pkg::FUNC_POP, 32'h0, 16'h0, 0, '0},
         '{bmhq_pkg::FUNC_REMOVE, 32'h0, 16'h1234, 0, '0},
         '{bmhq_pkg::FUNC_POP, 32'h0, 16'h0, 0, '0},
         '{bmhq_pkg::FUNC_POP, 32'h0, 16'h0, 0, '0},
         '{bmhq_pkg::FUNC_POP, 32'h0, 16'h0, 1, '{bmhq_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0, 0}}
      };
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) send_word(rows[i].func, rows[i].key, rows[i].tag,
                                  rows[i].given, rows[i].reply);
      // Fill to full, then one push too many, with reversed keys for deep sifts.
      for (int i = 0; i < DEPTH; i++) send_word(bmhq_pkg::FUNC_PUSH, 32'(DEPTH - i), 16'(i));
      send_word(bmhq_pkg::FUNC_PUSH, 32'h1, 16'h1);
      for (int i = 0; i < DEPTH; i++) send_word(bmhq_pkg::FUNC_POP, '0, '0);

      // Idling phases.
      random_burst(280);
      send_idle_pct = 77; random_burst(250);
      send_idle_pct = 0; recv_stall_pct = 77; random_burst(250);
      send_idle_pct = 27; recv_stall_pct = 27; random_burst(250);
      send_idle_pct = 0; recv_stall_pct = 0;
      // The receiver holds off while words keep coming, so the block backs up.
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         random_burst(80);
      join
      req_valid <= 0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
